@@ hw/rtl/dctc_pkg.sv @@
// ============================================================================
// dctc_pkg
// Types, codes and reset constants shared by the time-of-day clock modules.
// ============================================================================
`default_nettype none

package dctc_pkg;

  // Function codes carried by an input item.
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_READ_RAW = 3'd1;
  localparam logic [2:0] FUNC_READ_COR = 3'd2;
  localparam logic [2:0] FUNC_SET      = 3'd3;
  localparam logic [2:0] FUNC_STEP     = 3'd4;
  localparam logic [2:0] FUNC_DRIFT    = 3'd5;

  // Configuration register indexes.
  localparam int          CFG_INDEX_W            = 3;
  localparam int          CFG_DATA_W             = 32;
  localparam logic [2:0]  CFG_TICK_RESOLUTION    = 3'd0;
  localparam logic [2:0]  CFG_DRIFT_LIMIT        = 3'd1;
  localparam logic [2:0]  CFG_TICK_RATE_WHOLE    = 3'd2;
  localparam logic [2:0]  CFG_TICK_RATE_FRACTION = 3'd3;
  localparam logic [2:0]  CFG_TIMER_SCALE        = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_TICK_RESOLUTION    = 32'd4294967;
  localparam logic [30:0] RST_DRIFT_LIMIT        = 31'h7FFF_FFFF;
  localparam logic [15:0] RST_TICK_RATE_WHOLE    = 16'd1000;
  localparam logic [30:0] RST_TICK_RATE_FRACTION = 31'd0;
  localparam logic [31:0] RST_TIMER_SCALE        = 32'd0;

  // Rounding constant of the interpolation, one half in Q31.
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_4000_0000;

  // Shared multiplier operand A is signed and one bit wider than a word.
  localparam int MUL_A_W = 33;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FOLD,
    ST_SUM,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] in_func;
    logic [2:0] op_func;
    logic       out_free;
  } seq_in_t;

  typedef struct packed {
    logic in_ready;
    st_t  step;
    logic mul_en;
    logic commit;
  } seq_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/dctc_if.sv @@
// ============================================================================
// dctc_in_if / dctc_out_if
// Valid/ready channels for the clock's input items and result items.
// ============================================================================
`default_nettype none

interface dctc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [31:0]        timer_count;
  logic [63:0]        target_time;
  logic signed [63:0] step_amount;
  logic signed [31:0] drift_request;
  logic signed [31:0] error_estimate;

  modport source (output valid, func, timer_count, target_time, step_amount,
                  drift_request, error_estimate, input ready);
  modport sink   (input valid, func, timer_count, target_time, step_amount,
                  drift_request, error_estimate, output ready);
endinterface

interface dctc_out_if;
  logic               valid;
  logic               ready;
  logic               second_carry;
  logic [63:0]        time_value;
  logic signed [31:0] drift_per_second;

  modport source (output valid, second_carry, time_value, drift_per_second,
                  input ready);
  modport sink   (input valid, second_carry, time_value, drift_per_second,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dctc_mul.sv @@
// ============================================================================
// dctc_mul
// Shared signed-by-unsigned multiplier with a registered 64-bit product.
// ============================================================================
`default_nettype none

module dctc_mul
  import dctc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic [31:0]               b,
  output logic [63:0]                    prod
);

  logic signed [MUL_A_W+32:0] full;

  // B is zero extended so the product is a plain signed multiply.
  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[63:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dctc_seq.sv @@
// ============================================================================
// dctc_seq
// Sequencer that steps one item through the shared multiplier.
// ============================================================================
`default_nettype none

module dctc_seq
  import dctc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire seq_in_t sin,
  output seq_ctrl_t    ctrl
);

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sin.in_valid) begin
          if (sin.in_func inside {FUNC_READ_RAW, FUNC_READ_COR, FUNC_SET, FUNC_DRIFT}) begin
            state_next = ST_MUL0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: begin
        state_next = (sin.op_func == FUNC_DRIFT) ? ST_DONE : ST_FOLD;
      end
      ST_FOLD: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: begin
        if (sin.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready = (state == ST_IDLE);
    ctrl.step     = state;
    ctrl.mul_en   = (state inside {ST_MUL0, ST_MUL1, ST_MUL2});
    ctrl.commit   = (state == ST_DONE) && sin.out_free;
  end

endmodule

`default_nettype wire

@@ hw/rtl/drift_compensated_time_clock.sv @@
// ============================================================================
// drift_compensated_time_clock
// Drift-compensated 32.32 seconds time-of-day clock with interpolated reads.
// ============================================================================
// One item is taken at a time and worked through a single shared 33x32-bit
// multiplier under a small sequencer, so the figure that sets the rate is the
// number of products an item needs. A tick, an offset step or an unused code
// needs no product: it goes from the idle state straight to the done state,
// where its result is registered on commit before the next item is taken.
// A drift update needs three products (drift times resolution, drift word
// times the whole tick rate, drift word times the fractional tick rate).
// A read or a set needs three products for the interpolation (increment
// times timer count, then the low and high halves of that times the
// timer scale), then a fold step that folds and rounds them and a sum
// step that adds the stamp to the interpolation. Results go into an
// output register, so the next item is taken while a finished result still
// waits for its transfer; the sequencer only stalls when a second result is
// ready before the first has left. Configuration writes are taken in any
// cycle and must only come while the block is idle. A new tick resolution
// reaches the tick increment only at the next drift update.
// ============================================================================
`default_nettype none

module drift_compensated_time_clock
  import dctc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  dctc_in_if.sink                     req,
  dctc_out_if.source                  rsp
);

  // Configuration registers.
  logic [31:0] tick_resolution;
  logic [30:0] drift_limit;
  logic [15:0] tick_rate_whole;
  logic [30:0] tick_rate_fraction;
  logic [31:0] timer_scale;

  // Clock state.
  logic [63:0] stamp;
  logic [63:0] time_offset;
  logic [31:0] tick_increment;
  logic [31:0] drift_word;
  logic [31:0] jitter_average;

  // The item under work, captured at its transfer.
  logic [2:0]  op_func;
  logic [31:0] op_count;
  logic [63:0] op_target;
  logic [63:0] op_step;
  logic [31:0] op_drift;
  logic [31:0] op_err;

  // Working registers: hold32 keeps the high product half, the clamped
  // correction or the interpolation; hold64 keeps the low product, the
  // whole-rate drift product or the interpolated time.
  logic [31:0] hold32;
  logic [63:0] hold64;

  // Output register.
  logic        out_valid;
  logic        out_carry;
  logic [63:0] out_time;
  logic [31:0] out_dps;

  seq_in_t   sin;
  seq_ctrl_t ctrl;

  logic                      accept;
  logic                      out_free;
  logic                      is_drift;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [31:0]               mul_b;
  logic [63:0]               prod;

  assign accept   = req.valid && ctrl.in_ready;
  assign out_free = !out_valid || rsp.ready;
  assign is_drift = (op_func == FUNC_DRIFT);

  assign sin.in_valid = req.valid;
  assign sin.in_func  = req.func;
  assign sin.op_func  = op_func;
  assign sin.out_free = out_free;

  dctc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .sin  (sin),
    .ctrl (ctrl)
  );

  dctc_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_resolution    <= RST_TICK_RESOLUTION;
      drift_limit        <= RST_DRIFT_LIMIT;
      tick_rate_whole    <= RST_TICK_RATE_WHOLE;
      tick_rate_fraction <= RST_TICK_RATE_FRACTION;
      timer_scale        <= RST_TIMER_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_RESOLUTION:    tick_resolution    <= cfg_data;
        CFG_DRIFT_LIMIT:        drift_limit        <= cfg_data[30:0];
        CFG_TICK_RATE_WHOLE:    tick_rate_whole    <= cfg_data[15:0];
        CFG_TICK_RATE_FRACTION: tick_rate_fraction <= cfg_data[30:0];
        CFG_TIMER_SCALE:        timer_scale        <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Capture of the item. The drift request is clamped to plus or minus
  // the drift limit on the way in, so the first product can start at once.
  // ---------------------------------------------------------------------
  logic signed [31:0] lim_pos;
  logic signed [31:0] lim_neg;
  logic signed [31:0] drift_clamped;

  always_comb begin
    lim_pos = $signed({1'b0, drift_limit});
    lim_neg = -lim_pos;
    if (req.drift_request > lim_pos) begin
      drift_clamped = lim_pos;
    end else if (req.drift_request < lim_neg) begin
      drift_clamped = lim_neg;
    end else begin
      drift_clamped = req.drift_request;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func   <= req.func;
      op_count  <= req.timer_count;
      op_target <= req.target_time;
      op_step   <= req.step_amount;
      op_drift  <= drift_clamped;
      op_err    <= req.error_estimate;
    end
  end

  // ---------------------------------------------------------------------
  // Operand selection for the shared multiplier.
  // Read and set: inc*count, then low(p)*scale, then high(p)*scale.
  // Drift: clamp*resolution, then word*whole rate, then word*fraction.
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.step)
      ST_MUL0: begin
        if (is_drift) begin
          mul_a = $signed({op_drift[31], op_drift});
          mul_b = tick_resolution;
        end else begin
          mul_a = $signed({1'b0, tick_increment});
          mul_b = op_count;
        end
      end
      ST_MUL1: begin
        if (is_drift) begin
          // Drift word taken straight from the first product.
          mul_a = $signed({1'b0, prod[62], prod[62:32]});
          mul_b = {16'd0, tick_rate_whole};
        end else begin
          mul_a = $signed({1'b0, prod[31:0]});
          mul_b = timer_scale;
        end
      end
      ST_MUL2: begin
        if (is_drift) begin
          mul_a = $signed({hold32[31], hold32[31], hold32[31:1]});
          mul_b = {1'b0, tick_rate_fraction};
        end else begin
          mul_a = $signed({1'b0, hold32});
          mul_b = timer_scale;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Working registers.
  // ---------------------------------------------------------------------
  logic [63:0] fold_sum;

  // Only the low word of the high-half product survives the wrap at 64 bits.
  assign fold_sum = hold64 + ROUND_HALF + {prod[31:0], 32'd0};

  always_ff @(posedge clk) begin
    case (ctrl.step)
      ST_MUL1: hold32 <= is_drift ? prod[62:31] : prod[63:32];
      ST_MUL2: hold64 <= is_drift ? {32'd0, prod[31:0]} : prod;
      ST_FOLD: hold32 <= fold_sum[62:31];
      ST_SUM:  hold64 <= stamp + {32'd0, hold32};
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Finish of the item: results and state updates, applied on commit.
  // ---------------------------------------------------------------------
  logic [32:0] tick_sum;
  logic [63:0] stamp_ticked;
  logic [31:0] word_next;
  logic [32:0] jitter_sum;
  logic [32:0] jitter_adj;
  logic        res_carry;
  logic [63:0] res_time;
  logic [31:0] res_dps;

  always_comb begin
    tick_sum     = {1'b0, stamp[31:0]} + {1'b0, tick_increment};
    stamp_ticked = {stamp[63:32] + {31'd0, tick_sum[32]}, tick_sum[31:0]};
    word_next    = {hold32[31], hold32[31:1]};
    // Sum of two signed words, halved toward zero.
    jitter_sum   = {jitter_average[31], jitter_average} + {op_err[31], op_err};
    jitter_adj   = jitter_sum + {32'd0, jitter_sum[32]};

    res_carry = 1'b0;
    res_time  = '0;
    res_dps   = '0;
    case (op_func)
      FUNC_TICK:     res_carry = tick_sum[32];
      FUNC_READ_RAW: res_time  = hold64;
      FUNC_READ_COR: res_time  = hold64 + time_offset;
      FUNC_DRIFT:    res_dps   = hold64[31:0] + prod[62:31];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp          <= '0;
      time_offset    <= '0;
      tick_increment <= RST_TICK_RESOLUTION;
      drift_word     <= '0;
      jitter_average <= '0;
    end else if (ctrl.commit) begin
      case (op_func)
        FUNC_TICK: stamp       <= stamp_ticked;
        FUNC_SET:  time_offset <= op_target - hold64;
        FUNC_STEP: time_offset <= time_offset + op_step;
        FUNC_DRIFT: begin
          jitter_average <= jitter_adj[32:1];
          drift_word     <= word_next;
          tick_increment <= tick_resolution + hold32;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_carry <= res_carry;
      out_time  <= res_time;
      out_dps   <= res_dps;
    end
  end

  assign req.ready            = ctrl.in_ready;
  assign rsp.valid            = out_valid;
  assign rsp.second_carry     = out_carry;
  assign rsp.time_value       = out_time;
  assign rsp.drift_per_second = $signed(out_dps);

endmodule

`default_nettype wire

@@ hw/rtl/dctc_chk.sv @@
// ============================================================================
// dctc_chk
// Port-level checks of the time-of-day clock, bound to the top level.
// ============================================================================
`default_nettype none

module dctc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_carry,
  input wire logic [63:0] rsp_time,
  input wire logic [31:0] rsp_dps
);

  // The block works on one item at a time.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken while an item is still at work");

  // A waiting result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_carry)
      && $stable(rsp_time) && $stable(rsp_dps))
    else $error("waiting result changed");

  // No result straight out of reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown right after reset");

  // Only a tick raises the carry, and a tick gives no other field.
  a_carry_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_carry |-> rsp_time == 64'd0 && rsp_dps == 32'd0)
    else $error("carry together with another result field");

  // A drift result carries no time.
  a_drift_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_dps != 32'd0 |-> rsp_time == 64'd0)
    else $error("drift result together with a time value");

endmodule

bind drift_compensated_time_clock dctc_chk u_dctc_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_carry (rsp.second_carry),
  .rsp_time  (rsp.time_value),
  .rsp_dps   (rsp.drift_per_second)
);

`default_nettype wire
